[rtl/core/pts_pkg.sv]
`timescale 1ns / 1ps
package pts_pkg;
  localparam int PRIO_W = 8;
  localparam int DUR_W = 10;
  localparam int TIME_W = 16;
  localparam int TPUT_W = 29;
  localparam int IDX_W = 5;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [TPUT_W-1:0] TPUT_MAX = '1;

  typedef struct packed {
    logic [DUR_W-1:0]  cool;
    logic [DUR_W-1:0]  dur;
    logic [PRIO_W-1:0] prio;
  } entry_t;
endpackage

[rtl/core/priority_task_scheduler.sv]
`timescale 1ns / 1ps
// Task scheduler. Tasks load one per cycle into a MAX_TASKS entry store; a
// load beyond capacity is dropped and flagged. The item with tlast set starts
// a drain: for each stored task one store entry is scanned per cycle to find
// the next task (highest priority, earliest on a tie, or arrival order when
// order_mode is 1), then a restoring divider forms priority / time as a
// PRIO_W + FRACTION_BITS bit quotient. Input is held off during a drain.
module priority_task_scheduler import pts_pkg::*; #(
  parameter int MAX_TASKS = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // task_priority, task_duration, task_cooldown
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // task_index, completion_time, throughput_q16, overflow_seen
  output logic        m_tlast
);
  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int NUM_W = PRIO_W + FRACTION_BITS;
  localparam int SUM_W = ((NUM_W > TPUT_W) ? NUM_W : TPUT_W) + 1;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]           state;
  logic                 order_mode;
  entry_t               store [MAX_TASKS];
  entry_t               rd;
  logic [MAX_TASKS-1:0] served;
  logic [CW-1:0]        count;
  logic [CW-1:0]        done_cnt;
  logic                 ovf;
  logic [TIME_W-1:0]    tacc;
  logic [TPUT_W-1:0]    tput;
  logic [CW-1:0]        scan;
  logic [AW-1:0]        best;
  logic [PRIO_W-1:0]    best_prio;
  logic                 found;
  entry_t               scan_e;
  logic [TIME_W+1:0]    tsum;
  logic [TIME_W-1:0]    tsat;
  logic                 div_start;
  logic                 div_done;
  logic [NUM_W-1:0]     quo;
  logic [SUM_W-1:0]     qsum;
  logic [SUM_W-1:0]     tput_sum;
  logic [TPUT_W-1:0]    tput_sat;
  logic [AW-1:0]        scan_a;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_LOAD);
  assign scan_a    = scan[AW-1:0];
  assign tsum      = {2'b0, tacc} + (TIME_W+2)'(rd.dur) + (TIME_W+2)'(rd.cool);
  assign tsat      = (tsum > (TIME_W+2)'(TIME_MAX)) ? TIME_MAX : tsum[TIME_W-1:0];
  assign qsum      = (tsat == '0) ? (rd.prio != '0 ? SUM_W'(TPUT_MAX) : '0)
                                  : SUM_W'(quo);
  assign tput_sum  = SUM_W'(tput) + qsum;
  assign tput_sat  = (tput_sum > SUM_W'(TPUT_MAX)) ? TPUT_MAX : tput_sum[TPUT_W-1:0];

  pts_div #(.NUM_W(NUM_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({rd.prio, {FRACTION_BITS{1'b0}}}), .den(tsat),
    .done(div_done), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && count < CW'(MAX_TASKS)) begin
      store[count[AW-1:0]] <= s_tdata[27:0];
    end
    scan_e <= store[scan_a];
    rd     <= store[best];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      order_mode <= 1'b0;
      served     <= '0;
      count      <= '0;
      ovf        <= 1'b0;
      tacc       <= '0;
      tput       <= '0;
      m_tvalid   <= 1'b0;
      div_start  <= 1'b0;
      done_cnt   <= '0;
      scan       <= '0;
      found      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid) begin
        order_mode <= cfg_data;
      end
      case (state)
        S_LOAD: begin
          if (s_tvalid) begin
            if (count < CW'(MAX_TASKS)) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (s_tlast) begin
              state    <= S_SCAN;
              scan     <= '0;
              found    <= 1'b0;
              done_cnt <= '0;
            end
          end
        end
        S_SCAN: begin
          // scan_e is registered from store[scan], so it holds entry scan - 1; scan == count ends the pass
          if (scan != '0) begin
            if (!served[scan_a - AW'(1)] && (!found ||
                (!order_mode && scan_e.prio > best_prio))) begin
              best      <= scan_a - AW'(1);
              best_prio <= scan_e.prio;
              found     <= 1'b1;
            end
          end
          if (scan == count) begin
            state <= S_READ;
          end
          scan <= scan + CW'(1);
        end
        S_READ: begin
          if (scan == count + CW'(1)) begin
            scan <= '0;
          end else begin
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            served[best] <= 1'b1;
            tacc         <= tsat;
            tput         <= tput_sat;
            m_tdata      <= {5'b0, ovf, tput_sat, tsat, IDX_W'(best)};
            m_tlast      <= (done_cnt + CW'(1) == count);
            m_tvalid     <= 1'b1;
            done_cnt     <= done_cnt + CW'(1);
            state        <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state  <= S_LOAD;
              served <= '0;
              count  <= '0;
              ovf    <= 1'b0;
              tacc   <= '0;
              tput   <= '0;
            end else begin
              state <= S_SCAN;
              scan  <= '0;
              found <= 1'b0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("load accepted during drain");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TASKS)) else $error("task count beyond capacity");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && div_done |-> tsat >= tacc) else $error("time went backward");
endmodule

[rtl/core/pts_div.sv]
`timescale 1ns / 1ps
module pts_div import pts_pkg::*; #(
  parameter int NUM_W = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [TIME_W-1:0] den,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  num_sh;
  logic [TIME_W:0]   rem;
  logic [TIME_W-1:0] dv;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;

  assign trial = {rem[TIME_W-1:0], num_sh[NUM_W-1]};
  assign diff  = trial - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
      dv     <= den;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      if (!diff[TIME_W]) begin
        rem <= diff;
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end
endmodule

[tb/priority_task_scheduler_tb.sv]
`timescale 1ns / 1ps
module priority_task_scheduler_tb;
  import pts_pkg::*;

  localparam int CAPACITY = 32;
  localparam int FRAC = 16;
  localparam logic ORDER_PRIORITY = 1'b0;
  localparam logic ORDER_ARRIVAL = 1'b1;

  typedef struct packed {
    logic                overflow;
    logic [TPUT_W-1:0]   tput;
    logic [TIME_W-1:0]   ctime;
    logic [IDX_W-1:0]    idx;
    logic                last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;

  logic        order_mode_q = ORDER_PRIORITY;
  entry_t      pending_tasks[$];
  logic        dropped_load;
  result_t     expected_results[$];
  int          mismatches = 0;
  bit          calm = 1'b0;

  priority_task_scheduler dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Schedule the loaded set and queue one result per stored task.
  task automatic schedule_set();
    bit          served[CAPACITY];
    logic [31:0] clock_sum;
    logic [63:0] tput_sum;
    logic [63:0] quot;
    int          best;
    result_t     r;
    clock_sum = '0;
    tput_sum = '0;
    foreach (served[i]) served[i] = 1'b0;
    for (int k = 0; k < pending_tasks.size(); k++) begin
      best = -1;
      for (int i = 0; i < pending_tasks.size(); i++) begin
        if (served[i]) continue;
        if (best < 0) begin
          best = i;
          if (order_mode_q == ORDER_ARRIVAL) break;
        end else if (pending_tasks[i].prio > pending_tasks[best].prio) begin
          best = i;
        end
      end
      served[best] = 1'b1;
      clock_sum = clock_sum + pending_tasks[best].dur + pending_tasks[best].cool;
      if (clock_sum > TIME_MAX) clock_sum = 32'(TIME_MAX);
      if (clock_sum == 0)
        quot = (pending_tasks[best].prio != 0) ? 64'(TPUT_MAX) : 64'd0;
      else
        quot = (64'(pending_tasks[best].prio) << FRAC) / clock_sum;
      tput_sum = tput_sum + quot;
      if (tput_sum > TPUT_MAX) tput_sum = 64'(TPUT_MAX);
      r.idx = best[IDX_W-1:0];
      r.ctime = clock_sum[TIME_W-1:0];
      r.tput = tput_sum[TPUT_W-1:0];
      r.overflow = dropped_load;
      r.last = (k == pending_tasks.size() - 1);
      expected_results.push_back(r);
    end
    pending_tasks.delete();
    dropped_load = 1'b0;
  endtask

  task automatic send_task(input logic [7:0] prio, input logic [9:0] dur,
                           input logic [9:0] cool, input logic last);
    entry_t e;
    while (!calm && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, cool, dur, prio};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    e.prio = prio;
    e.dur = dur;
    e.cool = cool;
    if (pending_tasks.size() < CAPACITY) pending_tasks.push_back(e);
    else dropped_load = 1'b1;
    if (last) schedule_set();
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_order(input logic mode);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    order_mode_q = mode;
  endtask

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++)
      send_task(8'($urandom_range(255)), 10'($urandom_range(1023, 1)),
                10'($urandom_range(1023)), i == n - 1);
  endtask

  task automatic test_extremes();
    send_task(8'd0, 10'd1, 10'd0, 1'b1);
    send_task(8'd255, 10'd1023, 10'd1023, 1'b0);
    send_task(8'd255, 10'd1, 10'd0, 1'b0);
    send_task(8'd0, 10'd512, 10'd1023, 1'b0);
    send_task(8'd255, 10'd1, 10'd0, 1'b1);
  endtask

  task automatic test_ties();
    for (int i = 0; i < 6; i++) send_task(8'd100, 10'd7, 10'd3, i == 5);
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 32; i++) send_task(8'd255, 10'd1, 10'd0, 1'b0);
    send_task(8'd170, 10'd1023, 10'd1023, 1'b0);
    send_task(8'd85, 10'd682, 10'd341, 1'b1);
    for (int i = 0; i < 32; i++) send_task(8'(i * 8), 10'd1023, 10'd1023, i == 31);
  endtask

  task automatic test_random_sets();
    int sent;
    sent = 0;
    while (sent < 95) begin
      calm = (sent > 30 && sent < 60);
      if ($urandom_range(9) == 0) begin
        send_random_set(1);
        sent++;
      end else begin
        int n;
        n = ($urandom_range(19) == 0) ? $urandom_range(36, 30) : $urandom_range(8, 2);
        send_random_set(n);
        sent += n;
      end
      if ($urandom_range(7) == 0) wait_drained();
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= 13) || calm;
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result idx=%0d", m_tdata[4:0]);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tdata[4:0] != exp_r.idx) begin
          $error("task_index expected %0d actual %0d", exp_r.idx, m_tdata[4:0]);
          mismatches++;
        end
        if (m_tdata[20:5] != exp_r.ctime) begin
          $error("completion_time expected %0d actual %0d", exp_r.ctime, m_tdata[20:5]);
          mismatches++;
        end
        if (m_tdata[49:21] != exp_r.tput) begin
          $error("throughput_q16 expected %0d actual %0d", exp_r.tput, m_tdata[49:21]);
          mismatches++;
        end
        if (m_tdata[50] != exp_r.overflow) begin
          $error("overflow_seen expected %0d actual %0d", exp_r.overflow, m_tdata[50]);
          mismatches++;
        end
        if (m_tlast != exp_r.last) begin
          $error("last_result expected %0d actual %0d", exp_r.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dropped_load = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_order(ORDER_PRIORITY);
    test_extremes();
    test_ties();
    test_saturation();
    write_order(ORDER_ARRIVAL);
    test_extremes();
    test_ties();
    test_random_sets();
    write_order(ORDER_PRIORITY);
    test_ties();
    test_random_sets();
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
